// ===== rtl/gbr_pkg.sv =====
`default_nettype none
package gbr_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_W          = 13;   // row counters reach MAX_HEIGHT
  localparam int PIX_W          = 16;
  localparam int COEF_W         = 16;
  localparam int ACC_W          = 40;   // 49 taps of 16x16 products
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF3     = 3'd6;

  localparam logic [10:0]       RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [12:0]       RST_IMAGE_HEIGHT  = 13'd1024;
  localparam logic [1:0]        RST_KERNEL_RADIUS = 2'd2;
  localparam logic [COEF_W-1:0] RST_COEF_CENTER   = 16'd26386;
  localparam logic [COEF_W-1:0] RST_COEF_OFF1     = 16'd16004;
  localparam logic [COEF_W-1:0] RST_COEF_OFF2     = 16'd3571;
  localparam logic [COEF_W-1:0] RST_COEF_OFF3     = 16'd0;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] in_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/gaussian_blur_2d_replicate_core.sv =====
// Streaming 2D Gaussian blur, replicated borders, unsigned 8.8 pixels.
//
// Input channel (in_valid/in_stall/in_data): cmd 0 carries a pixel in raster
// order, cmd 1 is a flush tick that lets pending outputs drain after the
// last pixel. Output channel (out_valid/out_stall/out_data) returns at most
// one filtered pixel per input transaction, out_last marking the frame end.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written only while the block is idle.
//
// Throughput: one transaction at a time. A transaction that yields no
// result goes from S_CHECK back to S_IDLE; one that yields a result
// runs S_ISSUE, S_DRAIN and S_FINISH, its length set by the single read
// port of the line memory, which delivers one window tap per cycle into
// the multiply-accumulate unit; the output register loads as S_FINISH ends.
// The output register lets the next transaction be accepted while a result
// waits; a stalled receiver only holds the block once a second result is
// ready for the occupied register.
// Reset (rst, synchronous) restores the register defaults and clears the
// position counters; line memory content is left as is.
`default_nettype none
module gaussian_blur_2d_replicate_core #(
  parameter int MAX_RADIUS = gbr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire gbr_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output gbr_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RB   = $clog2(2 * MAX_RADIUS + 2);
  localparam int MAW  = RB + CW;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int DW   = $clog2(2 * MAX_RADIUS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_DRAIN, S_FINISH} state_t;

  state_t state;

  logic [10:0]       image_width;
  logic [12:0]       image_height;
  logic [1:0]        kernel_radius;
  logic [COEF_W-1:0] coef [4];

  logic [ROW_W-1:0] in_row, out_row;
  logic [CW-1:0]    in_col, out_col;
  logic [DW-1:0]    di, dj;
  logic [1:0]       drain_cnt;
  logic             last;
  logic             iss_v;
  logic [2*COEF_W-1:0] wt_prod;

  logic [WW-1:0]    w_sat;
  logic [ROW_W-1:0] h_sat;
  logic [RW-1:0]    r_sat;

  // saturated geometry
  always_comb begin
    if (image_width == '0) w_sat = WW'(1);
    else if (ROW_W'(image_width) > ROW_W'(MAX_WIDTH)) w_sat = WW'(MAX_WIDTH);
    else w_sat = WW'(image_width);
    if (image_height == '0) h_sat = ROW_W'(1);
    else if (image_height > ROW_W'(MAX_HEIGHT)) h_sat = ROW_W'(MAX_HEIGHT);
    else h_sat = image_height;
    if (kernel_radius == '0) r_sat = RW'(1);
    else if (kernel_radius > 2'(MAX_RADIUS)) r_sat = RW'(MAX_RADIUS);
    else r_sat = RW'(kernel_radius);
  end

  // restart check and input write, both on the accepting edge
  logic             restart;
  logic [ROW_W-1:0] cur_in_row, cur_out_row, in_row_next;
  logic [CW-1:0]    cur_in_col, cur_out_col, in_col_next;
  logic             do_write;

  always_comb begin
    restart = (WW'(in_col) >= w_sat) || (WW'(out_col) >= w_sat) ||
              (in_row > h_sat) || (out_row >= h_sat) ||
              (in_row == h_sat && in_col != '0);
    cur_in_row  = restart ? '0 : in_row;
    cur_in_col  = restart ? '0 : in_col;
    cur_out_row = restart ? '0 : out_row;
    cur_out_col = restart ? '0 : out_col;
    do_write = (in_data.cmd == CMD_PIXEL) && (cur_in_row < h_sat);
    in_row_next = cur_in_row;
    in_col_next = cur_in_col;
    if (do_write) begin
      if (WW'(cur_in_col) + WW'(1) >= w_sat) begin
        in_col_next = '0;
        in_row_next = cur_in_row + ROW_W'(1);
      end else begin
        in_col_next = cur_in_col + CW'(1);
      end
    end
  end

  // availability of the next output
  logic [ROW_W:0] nr;
  logic [WW:0]    nc;
  logic           avail;

  always_comb begin
    nr = {1'b0, out_row} + (ROW_W+1)'(r_sat);
    if (nr > {1'b0, h_sat - ROW_W'(1)}) nr = {1'b0, h_sat - ROW_W'(1)};
    nc = (WW+1)'(out_col) + (WW+1)'(r_sat);
    if (nc > {1'b0, w_sat - WW'(1)}) nc = {1'b0, w_sat - WW'(1)};
    avail = ({1'b0, in_row} > nr) ||
            ({1'b0, in_row} == nr && (WW+1)'(in_col) > nc);
  end

  // tap address and weight index
  logic signed [ROW_W+1:0] row_v;
  logic signed [WW:0]      col_v;
  logic [ROW_W-1:0]        rr;
  logic [CW-1:0]           cc;
  logic [DW-1:0]           di_off, dj_off;
  logic [DW-1:0]           side_m1;

  always_comb begin
    side_m1 = DW'({r_sat, 1'b0});
    row_v = $signed({2'b00, out_row}) + $signed((ROW_W+2)'(di)) -
            $signed((ROW_W+2)'(r_sat));
    col_v = $signed((WW+1)'(out_col)) + $signed((WW+1)'(dj)) -
            $signed((WW+1)'(r_sat));
    if (row_v < 0) rr = '0;
    else if (row_v >= $signed({2'b00, h_sat})) rr = h_sat - ROW_W'(1);
    else rr = row_v[ROW_W-1:0];
    if (col_v < 0) cc = '0;
    else if (col_v >= $signed({1'b0, w_sat})) cc = CW'(w_sat - WW'(1));
    else cc = col_v[CW-1:0];
    di_off = (di > DW'(r_sat)) ? di - DW'(r_sat) : DW'(r_sat) - di;
    dj_off = (dj > DW'(r_sat)) ? dj - DW'(r_sat) : DW'(r_sat) - dj;
  end

  logic issuing;
  assign issuing  = (state == S_ISSUE);
  assign in_stall = (state != S_IDLE);

  logic accept;
  assign accept = in_valid && !in_stall;

  // writes and reads never overlap: reads only run after the write edge
  logic [PIX_W-1:0] rd_data;
  gbr_line_mem #(.AW(MAW), .DW(PIX_W)) u_mem (
    .clk     (clk),
    .wr_en   (accept && do_write),
    .wr_addr ({cur_in_row[RB-1:0], cur_in_col}),
    .wr_data (in_data.in_pixel),
    .rd_en   (issuing),
    .rd_addr ({rr[RB-1:0], cc}),
    .rd_data (rd_data)
  );

  mac_ctl_t         mac_ctl;
  logic [ACC_W-1:0] acc;

  assign mac_ctl.clear = (state == S_CHECK);
  assign mac_ctl.valid = iss_v;

  gbr_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .px  (rd_data),
    .wt  (wt_prod[2*COEF_W-1:COEF_W]),
    .acc (acc)
  );

  // round and saturate
  logic [ACC_W-1:0] rounded;
  logic [PIX_W-1:0] result;
  always_comb begin
    rounded = (acc + ACC_W'(32768)) >> 16;
    result  = (rounded > ACC_W'(16'hFFFF)) ? 16'hFFFF : rounded[PIX_W-1:0];
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      kernel_radius <= RST_KERNEL_RADIUS;
      coef[0]       <= RST_COEF_CENTER;
      coef[1]       <= RST_COEF_OFF1;
      coef[2]       <= RST_COEF_OFF2;
      coef[3]       <= RST_COEF_OFF3;
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      out_valid     <= 1'b0;
      iss_v         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:   image_width   <= cfg_data[10:0];
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data[12:0];
          REG_KERNEL_RADIUS: kernel_radius <= cfg_data[1:0];
          REG_COEF_CENTER:   coef[0]       <= cfg_data;
          REG_COEF_OFF1:     coef[1]       <= cfg_data;
          REG_COEF_OFF2:     coef[2]       <= cfg_data;
          REG_COEF_OFF3:     coef[3]       <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      iss_v <= issuing;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            in_row  <= in_row_next;
            in_col  <= in_col_next;
            out_row <= cur_out_row;
            out_col <= cur_out_col;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (avail) begin
            last  <= (out_row == h_sat - ROW_W'(1)) &&
                     (WW'(out_col) == w_sat - WW'(1));
            di    <= '0;
            dj    <= '0;
            state <= S_ISSUE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ISSUE: begin
          wt_prod <= coef[di_off[1:0]] * coef[dj_off[1:0]];
          if (dj == side_m1) begin
            dj <= '0;
            if (di == side_m1) begin
              drain_cnt <= '0;
              state     <= S_DRAIN;
            end else begin
              di <= di + DW'(1);
            end
          end else begin
            dj <= dj + DW'(1);
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 2'd1;
          if (drain_cnt == 2'd2) state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_data.out_pixel <= result;
            out_data.out_last  <= last;
            if (last) begin
              in_row  <= '0;
              in_col  <= '0;
              out_row <= '0;
              out_col <= '0;
            end else if (WW'(out_col) + WW'(1) >= w_sat) begin
              out_col <= '0;
              out_row <= out_row + ROW_W'(1);
            end else begin
              out_col <= out_col + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gbr_line_mem.sv =====
`default_nettype none
module gbr_line_mem #(
  parameter int AW = 13,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gbr_mac.sv =====
`default_nettype none
module gbr_mac (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire gbr_pkg::mac_ctl_t        ctl,
  input  wire logic [gbr_pkg::PIX_W-1:0]  px,
  input  wire logic [gbr_pkg::COEF_W-1:0] wt,
  output logic      [gbr_pkg::ACC_W-1:0]  acc
);
  import gbr_pkg::*;

  logic [PIX_W+COEF_W-1:0] prod;
  logic                    prod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else if (ctl.clear) begin
      prod_v <= 1'b0;
      acc    <= '0;
    end else begin
      prod_v <= ctl.valid;
      if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (ctl.valid) begin
      prod <= px * wt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gbr_checker.sv =====
`default_nettype none
module gbr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire gbr_pkg::out_item_t out_data
);

  // sequential block: nothing accepted on the cycle after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // a result never appears without a preceding input transaction
  a_result_needs_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> in_stall || $past(in_stall))
    else $error("result without input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear channels");

endmodule

bind gaussian_blur_2d_replicate_core gbr_checker u_gbr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
